FILE: rtl/core/mrbq_pkg.sv
// Package for the multi-reader broadcast queue.
// Holds command/result word types, action and status codes, FSM states.
// No dependencies.
package mrbq_pkg;

  localparam int DATA_W = 32;
  localparam int PEER_W = 3;
  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    ACT_PUBLISH     = 2'd0,
    ACT_READ        = 2'd1,
    ACT_SUBSCRIBE   = 2'd2,
    ACT_UNSUBSCRIBE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_EMPTY   = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_NOT_SUB = 3'd3,
    STATUS_ALREADY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_TRIM = 2'd2
  } state_e;

  typedef struct packed {
    action_e             action;
    logic [PEER_W-1:0]   peer;
    logic [DATA_W-1:0]   data_in;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data_out;
    logic                has_data;
    status_e             status;
    logic                is_subscribed;
    logic                any_subscribers;
    logic [FILL_W-1:0]   fill_level;
  } res_t;

endpackage

FILE: rtl/core/multi_reader_broadcast_queue.sv
// Each accepted word runs the execute state; read and unsubscribe, unless the peer is
// not subscribed, also run the trim state before the result strobes. Words are handled
// one at a time: busy is high in the execute and trim states, and a new word is taken only once it drops.
// Reset (async, active low) empties the ring and drops all subscriptions; message
// memory is not cleared. Results cannot be stalled: each is valid for one cycle.
module multi_reader_broadcast_queue #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32,
  parameter int PEERS      = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mrbq_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  output mrbq_pkg::res_t    res_o
);

  // Pointers count modulo 2*DEPTH so full and empty stay distinct.
  localparam int PTR_W  = $clog2(2 * DEPTH);
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int LV     = $clog2(PEERS);
  localparam int LEAVES = 1 << LV;
  localparam logic [PTR_W:0]   SPAN_X  = (PTR_W + 1)'(2 * DEPTH);
  localparam logic [PTR_W-1:0] SPAN_M1 = PTR_W'(2 * DEPTH - 1);
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == SPAN_M1) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] to_p,
                                                input logic [PTR_W-1:0] from_p);
    logic [PTR_W:0] diff;
    if (to_p >= from_p) diff = {1'b0, to_p} - {1'b0, from_p};
    else                diff = {1'b0, to_p} + SPAN_X - {1'b0, from_p};
    return diff[PTR_W-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_idx(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] w;
    w = (p >= DEPTH_P) ? PTR_W'(p - DEPTH_P) : p;
    return w[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  mrbq_pkg::state_e state_q, state_d;
  logic [PTR_W-1:0] old_q, old_d;                 // oldest retained entry
  logic [PTR_W-1:0] app_q, app_d;                 // next append slot
  logic [PTR_W-1:0] rp_q [PEERS];                 // per-subscriber read position
  logic [PTR_W-1:0] rp_d [PEERS];
  logic [PEERS-1:0] sub_q, sub_d;                 // subscribed slots
  logic             res_valid_q, res_valid_d;

  mrbq_pkg::cmd_t   cmd_q;                        // command under execution
  mrbq_pkg::res_t   res_q, res_d;

  // Message store: single write port, registered read.
  logic [WORD_WIDTH-1:0] mem_q [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic                  accept;

  // ---------------------------------------------------------------------------
  // Peer decode for the incoming command (memory read issue) and the held one
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    in_pidx, ex_pidx;
  logic             in_ok, ex_ok;
  logic [PTR_W-1:0] in_rp, ex_rp;
  logic [PTR_W-1:0] fill_cur;

  assign accept  = start && (state_q == mrbq_pkg::S_IDLE);
  assign busy    = (state_q != mrbq_pkg::S_IDLE);

  assign in_pidx = PW'(cmd_i.peer);
  assign ex_pidx = PW'(cmd_q.peer);
  assign in_ok   = int'(cmd_i.peer) < PEERS;
  assign ex_ok   = int'(cmd_q.peer) < PEERS;
  assign in_rp   = in_ok ? rp_q[in_pidx] : '0;
  assign ex_rp   = ex_ok ? rp_q[ex_pidx] : '0;

  assign mem_raddr = ptr_idx(in_rp);
  assign mem_waddr = ptr_idx(app_q);
  assign fill_cur  = ptr_dist(app_q, old_q);

  // ---------------------------------------------------------------------------
  // Trim: minimum distance from the oldest pointer over subscribed read
  // positions, as a balanced compare tree. Unsubscribed leaves hold the span.
  // ---------------------------------------------------------------------------
  logic [PTR_W:0] tree [LV+1][LEAVES];
  logic [PTR_W:0] best;
  logic [PTR_W+1:0] old_sum;
  logic [PTR_W-1:0] old_trim;

  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        tree[l][i] = SPAN_X;
      end
    end
    for (int k = 0; k < PEERS; k++) begin
      if (sub_q[k]) tree[0][k] = {1'b0, ptr_dist(rp_q[k], old_q)};
    end
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        tree[l+1][i] = (tree[l][2*i] <= tree[l][2*i+1]) ? tree[l][2*i] : tree[l][2*i+1];
      end
    end
  end

  assign best     = tree[LV][0];
  assign old_sum  = {2'b00, old_q} + {1'b0, best};
  assign old_trim = (old_sum >= {1'b0, SPAN_X}) ? PTR_W'(old_sum - {1'b0, SPAN_X})
                                                : old_sum[PTR_W-1:0];

  // ---------------------------------------------------------------------------
  // Next state and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    logic trim_req;
    state_d     = state_q;
    old_d       = old_q;
    app_d       = app_q;
    rp_d        = rp_q;
    sub_d       = sub_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    trim_req    = 1'b0;

    case (state_q)
      mrbq_pkg::S_IDLE: begin
        if (start) state_d = mrbq_pkg::S_EXEC;
      end

      mrbq_pkg::S_EXEC: begin
        res_d.data_out = '0;
        res_d.has_data = 1'b0;
        res_d.status   = mrbq_pkg::STATUS_OK;
        case (cmd_q.action)
          mrbq_pkg::ACT_PUBLISH: begin
            // Drop the word when the ring is full.
            if (fill_cur >= DEPTH_P) begin
              res_d.status = mrbq_pkg::STATUS_FULL;
            end else begin
              mem_we = 1'b1;
              app_d  = ptr_inc(app_q);
            end
          end
          mrbq_pkg::ACT_READ: begin
            if (!(ex_ok && sub_q[ex_pidx])) begin
              res_d.status = mrbq_pkg::STATUS_NOT_SUB;
            end else if (ex_rp == app_q) begin
              res_d.status = mrbq_pkg::STATUS_EMPTY;
              trim_req     = 1'b1;
            end else begin
              res_d.data_out   = mrbq_pkg::DATA_W'(rdata_q);
              res_d.has_data   = 1'b1;
              rp_d[ex_pidx]    = ptr_inc(ex_rp);
              trim_req         = 1'b1;
            end
          end
          mrbq_pkg::ACT_SUBSCRIBE: begin
            if (!ex_ok) begin
              res_d.status = mrbq_pkg::STATUS_NOT_SUB;
            end else if (sub_q[ex_pidx]) begin
              res_d.status = mrbq_pkg::STATUS_ALREADY;
            end else begin
              sub_d[ex_pidx] = 1'b1;
              rp_d[ex_pidx]  = old_q;
            end
          end
          mrbq_pkg::ACT_UNSUBSCRIBE: begin
            if (!(ex_ok && sub_q[ex_pidx])) begin
              res_d.status = mrbq_pkg::STATUS_NOT_SUB;
            end else begin
              sub_d[ex_pidx] = 1'b0;
              trim_req       = 1'b1;
            end
          end
          default: begin
            res_d.status = mrbq_pkg::STATUS_NOT_SUB;
          end
        endcase

        if (trim_req) begin
          state_d = mrbq_pkg::S_TRIM;
        end else begin
          res_d.is_subscribed   = ex_ok && sub_d[ex_pidx];
          res_d.any_subscribers = |sub_d;
          res_d.fill_level      = mrbq_pkg::FILL_W'(ptr_dist(app_d, old_q));
          res_valid_d           = 1'b1;
          state_d               = mrbq_pkg::S_IDLE;
        end
      end

      mrbq_pkg::S_TRIM: begin
        // Advance the oldest pointer to the slowest subscriber, if any remain.
        if (|sub_q) old_d = old_trim;
        res_d.is_subscribed   = ex_ok && sub_q[ex_pidx];
        res_d.any_subscribers = |sub_q;
        res_d.fill_level      = mrbq_pkg::FILL_W'(ptr_dist(app_q, old_d));
        res_valid_d           = 1'b1;
        state_d               = mrbq_pkg::S_IDLE;
      end

      default: begin
        state_d = mrbq_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrbq_pkg::S_IDLE;
      old_q       <= '0;
      app_q       <= '0;
      rp_q        <= '{default: '0};
      sub_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      old_q       <= old_d;
      app_q       <= app_d;
      rp_q        <= rp_d;
      sub_q       <= sub_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold the command for the execute cycle; hold the result word.
  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_i;
    res_q <= res_d;
  end

  // Message memory. The write of a publish lands before any later read is
  // issued, since a new word is only taken once busy drops.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= WORD_WIDTH'(cmd_q.data_in);
    if (accept) rdata_q <= mem_q[mem_raddr];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobes in consecutive cycles");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.has_data) |-> (res_o.status == mrbq_pkg::STATUS_OK))
    else $error("read data reported with non-ok status");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrbq_pkg::S_IDLE) |-> (fill_cur <= DEPTH_P))
    else $error("ring fill exceeds depth");

  a_sub_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.is_subscribed) |-> res_o.any_subscribers)
    else $error("subscribed peer reported with no subscribers");
`endif

endmodule

FILE: test/multi_reader_broadcast_queue_tb.sv
// Self-checking testbench for multi_reader_broadcast_queue: directed and random command words,
// each result checked field by field against an in-bench model of the ring.
// Depends on mrbq_pkg and the multi_reader_broadcast_queue RTL.
module multi_reader_broadcast_queue_tb;
  import mrbq_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int SLOTS      = 8;
  localparam int RANDOM_WORDS = 550;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  cmd_t cmd_i  = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  multi_reader_broadcast_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of the ring: pointers count modulo twice the depth, so five bits wrap for free.
  logic [DATA_W-1:0] ring_words [RING_DEPTH];
  logic [4:0]        oldest_ptr;
  logic [4:0]        append_ptr;
  logic [4:0]        read_pos [SLOTS];
  logic [SLOTS-1:0]  sub_mask;

  // Expected results in order of acceptance; write and read counts index a small ring.
  res_t exp_ring [16];
  int   exp_wr     = 0;
  int   exp_rd     = 0;
  int   err_count  = 0;
  int   burst_left = 0;

  // Advance the oldest pointer to the least advanced read position among subscribers.
  // With nobody subscribed, hold everything.
  function automatic void trim_to_slowest_reader();
    int         best;
    logic [4:0] lag;
    if (sub_mask == '0) return;
    best = 2 * RING_DEPTH;
    for (int k = 0; k < SLOTS; k++) begin
      if (sub_mask[k]) begin
        lag = read_pos[k] - oldest_ptr;
        if (int'(lag) < best) best = int'(lag);
      end
    end
    oldest_ptr = oldest_ptr + 5'(best);
  endfunction

  // Apply one command word to the model and return the result it should produce.
  function automatic res_t ring_step(cmd_t c);
    res_t       r;
    logic [4:0] fill;
    logic [4:0] rp;
    r = '0;
    r.status = STATUS_OK;
    fill = append_ptr - oldest_ptr;
    case (c.action)
      ACT_PUBLISH: begin
        if (fill >= 5'(RING_DEPTH)) begin
          r.status = STATUS_FULL;
        end else begin
          ring_words[append_ptr[3:0]] = c.data_in;
          append_ptr = append_ptr + 5'd1;
        end
      end
      ACT_READ: begin
        if (!sub_mask[c.peer]) begin
          r.status = STATUS_NOT_SUB;
        end else if (read_pos[c.peer] == append_ptr) begin
          r.status = STATUS_EMPTY;
          trim_to_slowest_reader();
        end else begin
          rp = read_pos[c.peer];
          r.data_out = ring_words[rp[3:0]];
          r.has_data = 1'b1;
          read_pos[c.peer] = rp + 5'd1;
          trim_to_slowest_reader();
        end
      end
      ACT_SUBSCRIBE: begin
        if (sub_mask[c.peer]) begin
          r.status = STATUS_ALREADY;
        end else begin
          sub_mask[c.peer] = 1'b1;
          read_pos[c.peer] = oldest_ptr;
        end
      end
      default: begin
        if (!sub_mask[c.peer]) begin
          r.status = STATUS_NOT_SUB;
        end else begin
          sub_mask[c.peer] = 1'b0;
          trim_to_slowest_reader();
        end
      end
    endcase
    r.is_subscribed   = sub_mask[c.peer];
    r.any_subscribers = |sub_mask;
    r.fill_level      = append_ptr - oldest_ptr;
    return r;
  endfunction

  function automatic cmd_t make_cmd(action_e a, logic [PEER_W-1:0] p, logic [DATA_W-1:0] d);
    cmd_t c;
    c.action  = a;
    c.peer    = p;
    c.data_in = d;
    return c;
  endfunction

  // Present one command word and hold it until the block takes it (start high, busy low
  // at the edge). Keep start high inside a burst; at the end of a burst drop start for a
  // random gap so that idle cycles land on every phase of the execute/trim sequence.
  task automatic send_cmd(input cmd_t c);
    int gap;
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_ring[exp_wr[3:0]] = ring_step(c);
    exp_wr++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      // Mostly short bursts; now and then a long stretch with no idling at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Check each strobed result against the oldest expectation; keep running after a miss.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (exp_wr == exp_rd) begin
        $error("result strobed with no command outstanding");
        err_count++;
      end else begin
        want = exp_ring[exp_rd[3:0]];
        exp_rd++;
        if (res_o.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, res_o.data_out);
          err_count++;
        end
        if (res_o.has_data !== want.has_data) begin
          $error("has_data: expected %0d, got %0d", want.has_data, res_o.has_data);
          err_count++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          err_count++;
        end
        if (res_o.is_subscribed !== want.is_subscribed) begin
          $error("is_subscribed: expected %0d, got %0d", want.is_subscribed,
                 res_o.is_subscribed);
          err_count++;
        end
        if (res_o.any_subscribers !== want.any_subscribers) begin
          $error("any_subscribers: expected %0d, got %0d", want.any_subscribers,
                 res_o.any_subscribers);
          err_count++;
        end
        if (res_o.fill_level !== want.fill_level) begin
          $error("fill_level: expected %0d, got %0d", want.fill_level, res_o.fill_level);
          err_count++;
        end
      end
    end
  end

  // A fresh subscriber on an empty ring: read finds nothing new, a second subscribe is refused.
  task automatic test_empty_reads();
    send_cmd(make_cmd(ACT_SUBSCRIBE, 3'd3, 32'h0));
    send_cmd(make_cmd(ACT_READ, 3'd3, 32'h0));
    send_cmd(make_cmd(ACT_SUBSCRIBE, 3'd3, 32'h0));
  endtask

  // Slot 3 has read nothing, so nothing is trimmed: fill to the top, then overflow once.
  // The extremes of the data word go in first and the first read returns the all-zero word.
  task automatic test_fill_to_full();
    send_cmd(make_cmd(ACT_PUBLISH, 3'd0, 32'h0000_0000));
    send_cmd(make_cmd(ACT_PUBLISH, 3'd7, 32'hffff_ffff));
    for (int i = 0; i < RING_DEPTH - 2; i++) begin
      send_cmd(make_cmd(ACT_PUBLISH, 3'($urandom_range(0, 7)), $urandom()));
    end
    send_cmd(make_cmd(ACT_PUBLISH, 3'd5, 32'hdead_beef));
    send_cmd(make_cmd(ACT_READ, 3'd3, 32'h0));
  endtask

  // Read and unsubscribe of a free slot are refused; dropping the last subscriber trims nothing.
  task automatic test_slot_errors();
    send_cmd(make_cmd(ACT_READ, 3'd0, 32'h0));
    send_cmd(make_cmd(ACT_UNSUBSCRIBE, 3'd0, 32'h0));
    send_cmd(make_cmd(ACT_UNSUBSCRIBE, 3'd3, 32'h0));
  endtask

  // Random traffic in rounds; each round picks its own publish weight so the ring swings
  // between full and drained, and half the time the peers crowd onto a few slots so that
  // subscribed readers actually catch up and trim.
  task automatic test_random_traffic(input int n_words);
    int      pub_weight;
    int      pick;
    int      peer_top;
    action_e act;
    for (int n = 0; n < n_words; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 4))
          0:       pub_weight = 10;
          1:       pub_weight = 30;
          2:       pub_weight = 50;
          3:       pub_weight = 70;
          default: pub_weight = 90;
        endcase
        peer_top = ($urandom_range(0, 1) == 0) ? 2 : 7;
      end
      pick = $urandom_range(0, 99);
      if (pick < pub_weight) begin
        act = ACT_PUBLISH;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      act = ACT_READ;
        else if (pick < 8) act = ACT_SUBSCRIBE;
        else               act = ACT_UNSUBSCRIBE;
      end
      send_cmd(make_cmd(act, 3'($urandom_range(0, peer_top)), $urandom()));
    end
  endtask

  initial begin
    int waited;
    oldest_ptr = '0;
    append_ptr = '0;
    sub_mask   = '0;
    for (int k = 0; k < SLOTS; k++) read_pos[k] = '0;
    for (int k = 0; k < RING_DEPTH; k++) ring_words[k] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_fill_to_full();
    test_slot_errors();
    test_random_traffic(RANDOM_WORDS);

    // Stop sending, let the outstanding results drain, then allow a few trailing cycles.
    start <= 1'b0;
    waited = 0;
    while (exp_wr != exp_rd && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (exp_wr != exp_rd) begin
      $error("%0d results never arrived", exp_wr - exp_rd);
      err_count++;
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every word through execute and trim plus the longest gap).
  initial begin
    #500000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
